/* rtl/badpcm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block ADPCM decoder package
// Shared constants, block layout and predictor coefficient tables.
// ----------------------------------------------------------------------------
package badpcm_pkg;

	localparam int BLOCK_BYTES = 16;
	localparam int POS_W       = $clog2(BLOCK_BYTES);
	localparam int SAMPLE_W    = 16;
	localparam int COEF_W      = 8;
	localparam int FILTER_W    = 3;
	localparam int SHIFT_W     = 4;

	localparam logic [POS_W-1:0] POS_HEADER = POS_W'(0);
	localparam logic [POS_W-1:0] POS_FLAGS  = POS_W'(1);
	localparam logic [POS_W-1:0] POS_LAST   = POS_W'(BLOCK_BYTES - 1);

	localparam logic [7:0] FLAG_END = 8'd7;

	localparam logic [FILTER_W-1:0] FILTER_MAX = FILTER_W'(4);

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [COEF_W-1:0]   coef_t;

	// First tap coefficient, in 64ths.
	function automatic coef_t coef_a(input logic [FILTER_W-1:0] filter);
		coef_t c;
		unique case (filter)
			3'd1:    c = 8'sd60;
			3'd2:    c = 8'sd115;
			3'd3:    c = 8'sd98;
			3'd4:    c = 8'sd122;
			default: c = 8'sd0;
		endcase
		return c;
	endfunction

	// Second tap coefficient, in 64ths.
	function automatic coef_t coef_b(input logic [FILTER_W-1:0] filter);
		coef_t c;
		unique case (filter)
			3'd2:    c = -8'sd52;
			3'd3:    c = -8'sd55;
			3'd4:    c = -8'sd60;
			default: c = 8'sd0;
		endcase
		return c;
	endfunction

endpackage

/* rtl/block_adpcm_decoder_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block ADPCM decoder
// Decodes a byte stream of 16-byte ADPCM blocks into signed 16-bit samples.
// ----------------------------------------------------------------------------
// Usage:
// Bytes enter on data_byte/stream_start under byte_valid/byte_stall; a word is
// taken on a clock edge with byte_valid high and byte_stall low. Results leave
// on sample/end_of_sound/last under sample_valid/sample_stall.
// Each accepted byte sits in an input register while it is worked on. A
// header byte, a flag byte other than the end code, or any byte after the end
// marker completes at once and gives no result. The end flag gives one result.
// A data byte gives two results, one per nibble, one after the other, since
// the second sample is predicted from the first through the shared predictor
// and clamp, so a data byte holds the input register until its second nibble
// is done. Results are computed only while the output is free. A result is
// registered at the end of the cycle in which it is computed, so the first
// sample of a data byte follows the input register, the second once it leaves.
// While a result waits in the output register under stall, a byte that needs
// no result still completes and the next byte may be taken.
// Reset clears position, history, end mark and both valid registers.
// stream_start clears position, history and end mark before its byte.
// ----------------------------------------------------------------------------
module block_adpcm_decoder_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic [7:0]                            data_byte,
	input  logic                                  stream_start,
	input  logic                                  byte_valid,
	output logic                                  byte_stall,
	output logic signed [badpcm_pkg::SAMPLE_W-1:0] sample,
	output logic                                  end_of_sound,
	output logic                                  last,
	output logic                                  sample_valid,
	input  logic                                  sample_stall
);

	// Input stage.
	logic                               valid_s1;
	logic [7:0]                         byte_s1;
	logic                               phase_q;

	// Decoder state.
	logic [badpcm_pkg::POS_W-1:0]       pos_q;
	logic [badpcm_pkg::SHIFT_W-1:0]     shift_q;
	logic [badpcm_pkg::FILTER_W-1:0]    filter_q;
	badpcm_pkg::sample_t                hist1_q;
	badpcm_pkg::sample_t                hist2_q;
	logic                               ended_q;

	// Output stage.
	badpcm_pkg::sample_t                sample_q;
	logic                               eos_q;
	logic                               last_q;
	logic                               out_valid_q;

	logic                               out_free;
	logic                               is_header;
	logic                               is_flags;
	logic                               is_end_flag;
	logic                               is_data;
	logic                               need_slot;
	logic                               emit;
	logic                               done;
	logic                               load;
	logic                               restart;
	logic [badpcm_pkg::POS_W-1:0]       pos_next;
	logic [badpcm_pkg::FILTER_W-1:0]    filter_new;

	logic [3:0]                         nib;
	badpcm_pkg::sample_t                residual;
	logic signed [23:0]                 prod_a;
	logic signed [23:0]                 prod_b;
	logic signed [25:0]                 acc;
	logic signed [19:0]                 pred;
	logic signed [20:0]                 total;
	badpcm_pkg::sample_t                clamped;

	assign out_free    = !out_valid_q || !sample_stall;
	assign is_header   = (pos_q == badpcm_pkg::POS_HEADER);
	assign is_flags    = (pos_q == badpcm_pkg::POS_FLAGS);
	assign is_end_flag = is_flags && (byte_s1 == badpcm_pkg::FLAG_END);
	assign is_data     = !is_header && !is_flags;
	assign need_slot   = !ended_q && (is_end_flag || is_data);
	assign emit        = valid_s1 && need_slot && out_free;

	// A data byte finishes with its second nibble; everything else in one pass.
	always_comb begin
		if (!valid_s1) begin
			done = 1'b0;
		end else if (ended_q) begin
			done = 1'b1;
		end else if (is_data) begin
			done = emit && phase_q;
		end else if (is_end_flag) begin
			done = emit;
		end else begin
			done = 1'b1;
		end
	end

	assign byte_stall = valid_s1 && !done;
	assign load       = byte_valid && !byte_stall;
	assign restart    = load && stream_start;
	assign pos_next   = (pos_q == badpcm_pkg::POS_LAST) ?
		badpcm_pkg::POS_HEADER : pos_q + badpcm_pkg::POS_W'(1);
	assign filter_new = (byte_s1[7:4] <= 4'(badpcm_pkg::FILTER_MAX)) ?
		byte_s1[6:4] : '0;

	// Sample datapath: residual, two-tap prediction, clamp.
	assign nib      = phase_q ? byte_s1[7:4] : byte_s1[3:0];
	assign residual = $signed({nib, 12'b0}) >>> shift_q;
	assign prod_a   = hist1_q * badpcm_pkg::coef_a(filter_q);
	assign prod_b   = hist2_q * badpcm_pkg::coef_b(filter_q);
	assign acc      = 26'(prod_a) + 26'(prod_b) + 26'sd32;
	assign pred     = 20'(acc >>> 6);
	assign total    = 21'(pred) + 21'(residual);

	always_comb begin
		if (total > 21'sd32767) begin
			clamped = 16'sh7FFF;
		end else if (total < -21'sd32768) begin
			clamped = 16'sh8000;
		end else begin
			clamped = total[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_q  <= 1'b0;
			pos_q    <= '0;
			shift_q  <= '0;
			filter_q <= '0;
			hist1_q  <= '0;
			hist2_q  <= '0;
			ended_q  <= 1'b0;
		end else begin
			if (restart) begin
				// A stream start overrides the previous byte's position and history
				// updates, while a header's shift and filter still take effect.
				phase_q <= 1'b0;
				pos_q   <= '0;
				hist1_q <= '0;
				hist2_q <= '0;
				ended_q <= 1'b0;
				if (valid_s1 && !ended_q && is_header) begin
					shift_q  <= byte_s1[3:0];
					filter_q <= filter_new;
				end
			end else if (valid_s1 && !ended_q) begin
				if (is_header) begin
					shift_q  <= byte_s1[3:0];
					filter_q <= filter_new;
					pos_q    <= pos_next;
				end else if (is_flags) begin
					if (!is_end_flag || emit) begin
						pos_q <= pos_next;
					end
					if (is_end_flag && emit) begin
						ended_q <= 1'b1;
					end
				end else if (emit) begin
					hist1_q <= clamped;
					hist2_q <= hist1_q;
					phase_q <= !phase_q;
					if (phase_q) begin
						pos_q <= pos_next;
					end
				end
			end
			if (load) begin
				valid_s1 <= 1'b1;
			end else if (done) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_s1 <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!sample_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			sample_q <= is_data ? clamped : '0;
			eos_q    <= !is_data;
			last_q   <= !is_data || phase_q;
		end
	end

	assign sample       = sample_q;
	assign end_of_sound = eos_q;
	assign last         = last_q;
	assign sample_valid = out_valid_q;

endmodule

/* dv/block_adpcm_decoder_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block ADPCM decoder testbench
// Feeds streams of 16-byte ADPCM blocks, directed first and then random with
// broken blocks mixed in, and compares every sample against an in-bench
// decoder. Both handshakes see random idle and stall phases, and one long
// output hold-off backs the block up into its input.
// ----------------------------------------------------------------------------

typedef struct packed {
	badpcm_pkg::sample_t value;
	logic                eos;
	logic                fin;
} pcm_result_t;

class decoded_sample_board;
	pcm_result_t         pending[$];
	int                  mismatches;
	logic [3:0]          next_pos;
	logic [3:0]          shift;
	logic [2:0]          filter;
	badpcm_pkg::sample_t hist_one;
	badpcm_pkg::sample_t hist_two;
	bit                  ended;

	function new();
		mismatches = 0;
		next_pos   = '0;
		shift      = '0;
		filter     = '0;
		hist_one   = '0;
		hist_two   = '0;
		ended      = 1'b0;
	endfunction

	// Prediction taps in 64ths for filters 0 to 4.
	function int tap_first(logic [2:0] f);
		case (f)
			3'd1:    return 60;
			3'd2:    return 115;
			3'd3:    return 98;
			3'd4:    return 122;
			default: return 0;
		endcase
	endfunction

	function int tap_second(logic [2:0] f);
		case (f)
			3'd2:    return -52;
			3'd3:    return -55;
			3'd4:    return -60;
			default: return 0;
		endcase
	endfunction

	function badpcm_pkg::sample_t decode_nibble(logic [3:0] nib);
		int resid;
		int guess;
		resid = int'($signed({nib, 12'h000})) >>> shift;
		guess = (int'(hist_one) * tap_first(filter) + int'(hist_two) * tap_second(filter)
			+ 32) >>> 6;
		resid = resid + guess;
		if (resid > 32767)
			resid = 32767;
		if (resid < -32768)
			resid = -32768;
		hist_two = hist_one;
		hist_one = resid[15:0];
		return resid[15:0];
	endfunction

	// Notes one accepted word; returns 1 unless the decoder ignores it.
	function bit take_byte(logic [7:0] d, logic start);
		logic [3:0] pos;
		if (start) begin
			next_pos = '0;
			hist_one = '0;
			hist_two = '0;
			ended    = 1'b0;
		end
		if (ended)
			return 1'b0;
		pos      = next_pos;
		next_pos = next_pos + 4'd1;
		if (pos == badpcm_pkg::POS_HEADER) begin
			shift  = d[3:0];
			filter = (d[7:4] <= 4'(badpcm_pkg::FILTER_MAX)) ? d[6:4] : 3'd0;
		end else if (pos == badpcm_pkg::POS_FLAGS) begin
			if (d == badpcm_pkg::FLAG_END) begin
				ended = 1'b1;
				pending.push_back('{value: '0, eos: 1'b1, fin: 1'b1});
			end
		end else begin
			pending.push_back('{value: decode_nibble(d[3:0]), eos: 1'b0, fin: 1'b0});
			pending.push_back('{value: decode_nibble(d[7:4]), eos: 1'b0, fin: 1'b1});
		end
		return 1'b1;
	endfunction

	task report_mismatch(string what);
		mismatches++;
		$display("mismatch: %s", what);
	endtask

	task check_sample(badpcm_pkg::sample_t got, logic got_eos, logic got_last);
		pcm_result_t want;
		if (pending.size() == 0) begin
			report_mismatch($sformatf("unexpected word, sample %0d", got));
		end else begin
			want = pending.pop_front();
			if (got !== want.value)
				report_mismatch($sformatf("sample %0d, want %0d", got, want.value));
			if (got_eos !== want.eos)
				report_mismatch($sformatf("end_of_sound %b, want %b", got_eos, want.eos));
			if (got_last !== want.fin)
				report_mismatch($sformatf("last %b, want %b", got_last, want.fin));
		end
	endtask

	task check_drained();
		if (pending.size() != 0)
			report_mismatch($sformatf("%0d samples never arrived", pending.size()));
	endtask
endclass

module block_adpcm_decoder_unit_tb;

	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 20;
	localparam int PHASE_ITEMS = 150;

	logic                clk;
	logic                arst_n;
	logic [7:0]          data_byte;
	logic                stream_start;
	logic                byte_valid;
	logic                byte_stall;
	badpcm_pkg::sample_t sample;
	logic                end_of_sound;
	logic                last;
	logic                sample_valid;
	logic                sample_stall;

	decoded_sample_board board = new();

	int idle_pct;
	int stall_pct;
	int hold_len;
	int hold_req;
	int handled_bytes;
	int cycles;

	// Bit 8 is stream_start, bits 7:0 the stream byte.
	logic [8:0] opening_words [25] = '{
		9'h140, 9'h002, 9'h077, 9'h077, 9'h088, 9'h088, 9'h00F, 9'h0F0,
		9'h000, 9'h0FF, 9'h012, 9'h034, 9'h056, 9'h09A, 9'h0BC, 9'h0DE,
		9'h0F3, 9'h007, 9'h05A, 9'h13D, 9'h0A5, 9'h081, 9'h12F, 9'h0C4,
		9'h0E1
	};

	block_adpcm_decoder_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.data_byte    (data_byte),
		.stream_start (stream_start),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.sample       (sample),
		.end_of_sound (end_of_sound),
		.last         (last),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("block_adpcm_decoder_unit_tb: done, errors");
			$finish;
		end
	end

	// Output side: checks each accepted word, then picks the next stall.
	initial begin
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		sample_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (sample_valid && !sample_stall)
				board.check_sample(sample, end_of_sound, last);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = hold_len;
			end
			if (hold_left > 0) begin
				hold_left--;
				sample_stall <= 1'b1;
			end else begin
				sample_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	task automatic send_byte(input logic [7:0] d, input logic start);
		while ($urandom_range(99) < idle_pct) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid   <= 1'b1;
		data_byte    <= d;
		stream_start <= start;
		do @(posedge clk); while (byte_stall);
		if (board.take_byte(d, start))
			handled_bytes++;
	endtask

	// A stray restart now and then breaks a block in the middle.
	function automatic logic stray_start();
		return ($urandom_range(49) == 0);
	endfunction

	task automatic send_stream();
		int         blocks;
		int         strays;
		logic [7:0] head;
		logic [7:0] flag;
		blocks = $urandom_range(1, 4);
		for (int b = 0; b < blocks; b++) begin
			head[3:0] = 4'($urandom_range(15));
			head[7:4] = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) :
				4'($urandom_range(4));
			send_byte(head, (b == 0) || stray_start());
			flag = 8'($urandom_range(255));
			if ($urandom_range(11) == 0)
				flag = badpcm_pkg::FLAG_END;
			send_byte(flag, stray_start());
			if (flag == badpcm_pkg::FLAG_END) begin
				strays = $urandom_range(3);
				for (int k = 0; k < strays; k++)
					send_byte(8'($urandom_range(255)), 1'b0);
				return;
			end
			for (int k = 2; k < badpcm_pkg::BLOCK_BYTES; k++)
				send_byte(8'($urandom_range(255)), stray_start());
		end
	endtask

	task automatic run_phase(input int idle, input int stall, input int target);
		idle_pct  = idle;
		stall_pct = stall;
		while (handled_bytes < target)
			send_stream();
	endtask

	initial begin
		arst_n        <= 1'b0;
		byte_valid    <= 1'b0;
		data_byte     <= '0;
		stream_start  <= 1'b0;
		idle_pct      = 0;
		stall_pct     = 0;
		hold_len      = 0;
		hold_req      = 0;
		handled_bytes = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening_words[i])
			send_byte(opening_words[i][7:0], opening_words[i][8]);

		// The output holds off for a long stretch while words keep coming.
		hold_len = 250;
		hold_req++;
		run_phase(0, 0, handled_bytes + PHASE_ITEMS);
		run_phase(74, 0, handled_bytes + PHASE_ITEMS);
		run_phase(0, 74, handled_bytes + PHASE_ITEMS);
		run_phase(23, 23, handled_bytes + PHASE_ITEMS);

		byte_valid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		board.check_drained();
		if (board.mismatches == 0)
			$display("block_adpcm_decoder_unit_tb: done, clean");
		else
			$display("block_adpcm_decoder_unit_tb: done, errors");
		$finish;
	end

endmodule
